/* rtl/core/ebp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ebp_pkg
// Shared types, constants and helpers of the elastic ball physics step.
// ----------------------------------------------------------------------------
package ebp_pkg;

   localparam int BALL_COUNT_DEF = 16;

   localparam int CSR_IW = 3;
   localparam int CSR_DW = 32;

   localparam logic [CSR_IW-1:0] CSR_GRAVITY = 3'd0;
   localparam logic [CSR_IW-1:0] CSR_RADIUS  = 3'd1;
   localparam logic [CSR_IW-1:0] CSR_X_LOW   = 3'd2;
   localparam logic [CSR_IW-1:0] CSR_X_HIGH  = 3'd3;
   localparam logic [CSR_IW-1:0] CSR_Y_LOW   = 3'd4;
   localparam logic [CSR_IW-1:0] CSR_Y_HIGH  = 3'd5;

   localparam logic REQ_LOAD = 1'b0;
   localparam logic REQ_STEP = 1'b1;

   localparam logic signed [31:0] GRAVITY_RST = -32'sd642908;
   localparam logic [30:0]        RADIUS_RST  = 31'd32768;
   localparam logic signed [31:0] X_LOW_RST   = -32'sd655360;
   localparam logic signed [31:0] X_HIGH_RST  = 32'sd655360;
   localparam logic signed [31:0] Y_LOW_RST   = -32'sd655360;
   localparam logic signed [31:0] Y_HIGH_RST  = 32'sd655360;

   localparam int NORM_SHIFT = 28;
   localparam int SQRT_STEPS = 32;
   localparam int DIV_STEPS  = NORM_SHIFT + 1;

   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] vx;
      logic signed [31:0] vy;
   } ball_type;

   typedef enum logic [5:0] {
      ST_IDLE,
      ST_PREP_G,
      ST_PREP_R,
      ST_PREP_T,
      ST_INT_RD,
      ST_INT_LD,
      ST_INT_VY,
      ST_INT_PX,
      ST_INT_PY,
      ST_WXL,
      ST_WXH,
      ST_WYL,
      ST_WYH,
      ST_INT_WR,
      ST_PA_RD,
      ST_PA_LD,
      ST_PB_RD,
      ST_PB_LD,
      ST_DIST,
      ST_SQX,
      ST_SQY,
      ST_D2,
      ST_SQRT,
      ST_DIVX_INIT,
      ST_DIVX_RUN,
      ST_DIVY_INIT,
      ST_DIVY_RUN,
      ST_VA1,
      ST_VA2,
      ST_VB1,
      ST_VB2,
      ST_K,
      ST_DDX,
      ST_DDY,
      ST_UPDY,
      ST_PB_WR,
      ST_PA_WR,
      ST_EM_RD,
      ST_EM_OUT
   } state_type;

   function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
      logic signed [31:0] r;
      if (v > 48'sd2147483647) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < -48'sd2147483648) begin
         r = 32'sh8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage
`default_nettype wire

/* rtl/core/elastic_ball_physics_step.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// elastic_ball_physics_step
// Ball state store with gravity, wall reflection and pairwise elastic
// exchange, all in Q16.16, driven by a small sequencer around one multiplier.
// ----------------------------------------------------------------------------
// A load request writes one ball and busy stays low. A step request keeps
// busy high until its last result has been shown: every product goes
// through the one shared multiplier, and each overlapping pair runs a
// 32-step square root and two 29-step divisions. The sixteen results come
// out one at a time, ball 0 first, each on the rsp_ ports for one cycle
// under rsp_valid; they cannot be held off. Ball state lives in a memory
// with one read and one write port and a valid bit per ball.
module elastic_ball_physics_step #(
   parameter int BALL_COUNT = ebp_pkg::BALL_COUNT_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic                          req_type,
   input  wire logic [3:0]                    req_ball_index,
   input  wire logic signed [31:0]            req_load_x,
   input  wire logic signed [31:0]            req_load_y,
   input  wire logic signed [31:0]            req_load_vx,
   input  wire logic signed [31:0]            req_load_vy,
   input  wire logic [15:0]                   req_time_delta,
   output logic                               rsp_valid,
   output logic [3:0]                         rsp_out_index,
   output logic signed [31:0]                 rsp_out_x,
   output logic signed [31:0]                 rsp_out_y,
   output logic signed [31:0]                 rsp_out_vx,
   output logic signed [31:0]                 rsp_out_vy,
   output logic                               rsp_last_ball,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [ebp_pkg::CSR_IW-1:0]    csr_index,
   input  wire logic [ebp_pkg::CSR_DW-1:0]    csr_data
);
   import ebp_pkg::*;

   localparam int BW = (BALL_COUNT > 1) ? $clog2(BALL_COUNT) : 1;
   localparam int IW = (BW > 4) ? BW : 4;
   localparam logic [BW-1:0] LAST = BW'(BALL_COUNT - 1);

   state_type state_ff, state_in;
   logic [BW-1:0] i_ff, i_in, j_ff, j_in;

   logic signed [31:0] grav_ff, grav_in;
   logic [30:0]        radius_ff, radius_in;
   logic signed [31:0] xlo_ff, xlo_in, xhi_ff, xhi_in, ylo_ff, ylo_in, yhi_ff, yhi_in;

   logic [15:0]        dt_ff, dt_in;
   logic signed [31:0] gdt_ff, gdt_in;
   logic [63:0]        tr2_ff, tr2_in;
   ball_type           a_ff, a_in, b_ff, b_in;
   logic signed [32:0] dx_ff, dx_in, dy_ff, dy_in;
   logic [63:0]        sx_ff, sx_in;
   logic signed [68:0] mul_q_ff, mul_q_in;
   logic signed [35:0] mul_a;
   logic signed [32:0] mul_b;
   logic [63:0]        sq_v_ff, sq_v_in, sq_res_ff, sq_res_in, sq_bit_ff, sq_bit_in;
   logic [4:0]         cnt_ff, cnt_in;
   logic [31:0]        rem_ff, rem_in;
   logic [DIV_STEPS-1:0] sh_ff, sh_in;
   logic signed [29:0] nx_ff, nx_in, ny_ff, ny_in;
   logic signed [61:0] p1_ff, p1_in;
   logic signed [34:0] vna_ff, vna_in;
   logic signed [35:0] k_ff, k_in;

   logic               rsp_valid_ff, rsp_valid_in, rsp_last_ff, rsp_last_in;
   logic [3:0]         rsp_idx_ff, rsp_idx_in;
   ball_type           rsp_ball_ff, rsp_ball_in;

   ball_type           ball_mem [BALL_COUNT];
   logic [BALL_COUNT-1:0] valid_ff;
   ball_type           mem_q_ff;
   logic               vld_q_ff;
   ball_type           rd_ball;
   logic [BW-1:0]      rd_addr, wr_addr;
   logic               wr_en;
   ball_type           wr_data;

   logic               accept;
   logic [IW-1:0]      load_idx, idx_w;
   logic signed [31:0] rs;
   logic [64:0]        d2_sum, sq_try;
   logic [63:0]        d2;
   logic               sq_ge, div_ge;
   logic [32:0]        div_t;
   logic [32:0]        div_src;
   logic [31:0]        div_mag;
   logic signed [29:0] quot;
   logic signed [62:0] dot;
   logic signed [40:0] dd;

   assign busy      = (state_ff != ST_IDLE) || rsp_valid_ff;
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;
   assign load_idx  = IW'(req_ball_index);
   assign idx_w     = IW'(i_ff);
   assign rd_ball   = vld_q_ff ? mem_q_ff : '0;
   assign rs        = $signed({1'b0, radius_ff});
   assign mul_q_in  = mul_a * mul_b;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_index = rsp_idx_ff;
   assign rsp_out_x     = rsp_ball_ff.x;
   assign rsp_out_y     = rsp_ball_ff.y;
   assign rsp_out_vx    = rsp_ball_ff.vx;
   assign rsp_out_vy    = rsp_ball_ff.vy;
   assign rsp_last_ball = rsp_last_ff;

   // datapath helpers
   assign d2_sum = {1'b0, sx_ff} + {1'b0, mul_q_ff[63:0]};
   assign d2     = d2_sum[64] ? '1 : d2_sum[63:0];
   assign sq_try = {1'b0, sq_res_ff} + {1'b0, sq_bit_ff};
   assign sq_ge  = {1'b0, sq_v_ff} >= sq_try;
   assign div_t  = {rem_ff, sh_ff[DIV_STEPS-1]};
   assign div_ge = div_t >= {1'b0, sq_res_ff[31:0]};
   assign div_src = (state_ff == ST_DIVX_INIT || state_ff == ST_DIVX_RUN) ? dx_ff : dy_ff;
   assign div_mag = div_src[32] ? 32'(-div_src) : div_src[31:0];
   assign quot    = div_src[32] ? -$signed({1'b0, sh_in}) : $signed({1'b0, sh_in});
   assign dot     = 63'(p1_ff) + 63'($signed(mul_q_ff[61:0]));
   assign dd      = $signed(mul_q_ff[68:NORM_SHIFT]);

   // multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_PREP_G: begin
            mul_a = 36'(grav_ff);
            mul_b = $signed({17'b0, dt_ff});
         end
         ST_PREP_R: begin
            mul_a = $signed({4'b0, radius_ff, 1'b0});
            mul_b = $signed({1'b0, radius_ff, 1'b0});
         end
         ST_INT_VY: begin
            mul_a = 36'(a_ff.vx);
            mul_b = $signed({17'b0, dt_ff});
         end
         ST_INT_PX: begin
            mul_a = 36'(a_ff.vy);
            mul_b = $signed({17'b0, dt_ff});
         end
         ST_SQX: begin
            mul_a = 36'(dx_ff);
            mul_b = dx_ff;
         end
         ST_SQY: begin
            mul_a = 36'(dy_ff);
            mul_b = dy_ff;
         end
         ST_VA1: begin
            mul_a = 36'(a_ff.vx);
            mul_b = 33'(nx_ff);
         end
         ST_VA2: begin
            mul_a = 36'(a_ff.vy);
            mul_b = 33'(ny_ff);
         end
         ST_VB1: begin
            mul_a = 36'(b_ff.vx);
            mul_b = 33'(nx_ff);
         end
         ST_VB2: begin
            mul_a = 36'(b_ff.vy);
            mul_b = 33'(ny_ff);
         end
         ST_DDX: begin
            mul_a = k_ff;
            mul_b = 33'(nx_ff);
         end
         ST_DDY: begin
            mul_a = k_ff;
            mul_b = 33'(ny_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      grav_in      = grav_ff;
      radius_in    = radius_ff;
      xlo_in       = xlo_ff;
      xhi_in       = xhi_ff;
      ylo_in       = ylo_ff;
      yhi_in       = yhi_ff;
      dt_in        = dt_ff;
      gdt_in       = gdt_ff;
      tr2_in       = tr2_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      sx_in        = sx_ff;
      sq_v_in      = sq_v_ff;
      sq_res_in    = sq_res_ff;
      sq_bit_in    = sq_bit_ff;
      cnt_in       = cnt_ff;
      rem_in       = rem_ff;
      sh_in        = sh_ff;
      nx_in        = nx_ff;
      ny_in        = ny_ff;
      p1_in        = p1_ff;
      vna_in       = vna_ff;
      k_in         = k_ff;
      rsp_valid_in = 1'b0;
      rsp_last_in  = rsp_last_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_ball_in  = rsp_ball_ff;
      rd_addr      = i_ff;
      wr_en        = 1'b0;
      wr_addr      = i_ff;
      wr_data      = a_ff;

      if (csr_valid) begin
         unique case (csr_index)
            CSR_GRAVITY: grav_in   = $signed(csr_data);
            CSR_RADIUS:  radius_in = csr_data[30:0];
            CSR_X_LOW:   xlo_in    = $signed(csr_data);
            CSR_X_HIGH:  xhi_in    = $signed(csr_data);
            CSR_Y_LOW:   ylo_in    = $signed(csr_data);
            CSR_Y_HIGH:  yhi_in    = $signed(csr_data);
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_type == REQ_STEP) begin
                  dt_in    = req_time_delta;
                  state_in = ST_PREP_G;
               end else if (int'(req_ball_index) < BALL_COUNT) begin
                  wr_en   = 1'b1;
                  wr_addr = load_idx[BW-1:0];
                  wr_data = '{x: req_load_x, y: req_load_y, vx: req_load_vx, vy: req_load_vy};
               end
            end
         end
         ST_PREP_G: state_in = ST_PREP_R;
         ST_PREP_R: begin
            gdt_in   = $signed(mul_q_ff[47:16]);
            state_in = ST_PREP_T;
         end
         ST_PREP_T: begin
            tr2_in   = mul_q_ff[63:0];
            i_in     = '0;
            state_in = ST_INT_RD;
         end
         ST_INT_RD: state_in = ST_INT_LD;
         ST_INT_LD: begin
            a_in     = rd_ball;
            state_in = ST_INT_VY;
         end
         ST_INT_VY: begin
            a_in.vy  = sat32(48'(a_ff.vy) + 48'(gdt_ff));
            state_in = ST_INT_PX;
         end
         ST_INT_PX: begin
            a_in.x   = sat32(48'(a_ff.x) + 48'($signed(mul_q_ff[47:16])));
            state_in = ST_INT_PY;
         end
         ST_INT_PY: begin
            a_in.y   = sat32(48'(a_ff.y) + 48'($signed(mul_q_ff[47:16])));
            state_in = ST_WXL;
         end
         ST_WXL: begin
            if (48'(a_ff.x) - 48'(rs) < 48'(xlo_ff)) begin
               a_in.x  = sat32(48'(xlo_ff) + 48'(rs));
               a_in.vx = sat32(-48'(a_ff.vx));
            end
            state_in = ST_WXH;
         end
         ST_WXH: begin
            if (48'(a_ff.x) + 48'(rs) > 48'(xhi_ff)) begin
               a_in.x  = sat32(48'(xhi_ff) - 48'(rs));
               a_in.vx = sat32(-48'(a_ff.vx));
            end
            state_in = ST_WYL;
         end
         ST_WYL: begin
            if (48'(a_ff.y) - 48'(rs) < 48'(ylo_ff)) begin
               a_in.y  = sat32(48'(ylo_ff) + 48'(rs));
               a_in.vy = sat32(-48'(a_ff.vy));
            end
            state_in = ST_WYH;
         end
         ST_WYH: begin
            if (48'(a_ff.y) + 48'(rs) > 48'(yhi_ff)) begin
               a_in.y  = sat32(48'(yhi_ff) - 48'(rs));
               a_in.vy = sat32(-48'(a_ff.vy));
            end
            state_in = ST_INT_WR;
         end
         ST_INT_WR: begin
            wr_en = 1'b1;
            if (i_ff == LAST) begin
               i_in     = '0;
               state_in = ST_PA_RD;
            end else begin
               i_in     = i_ff + BW'(1);
               state_in = ST_INT_RD;
            end
         end
         ST_PA_RD: state_in = ST_PA_LD;
         ST_PA_LD: begin
            a_in     = rd_ball;
            j_in     = i_ff + BW'(1);
            state_in = ST_PB_RD;
         end
         ST_PB_RD: begin
            rd_addr  = j_ff;
            state_in = ST_PB_LD;
         end
         ST_PB_LD: begin
            b_in     = rd_ball;
            state_in = ST_DIST;
         end
         ST_DIST: begin
            dx_in    = 33'(b_ff.x) - 33'(a_ff.x);
            dy_in    = 33'(b_ff.y) - 33'(a_ff.y);
            state_in = ST_SQX;
         end
         ST_SQX: state_in = ST_SQY;
         ST_SQY: begin
            sx_in    = mul_q_ff[63:0];
            state_in = ST_D2;
         end
         ST_D2: begin
            if (d2 == '0 || d2 >= tr2_ff) begin
               state_in = ST_PB_WR;
            end else begin
               sq_v_in   = d2;
               sq_res_in = '0;
               sq_bit_in = 64'h4000_0000_0000_0000;
               cnt_in    = '0;
               state_in  = ST_SQRT;
            end
         end
         ST_SQRT: begin
            if (sq_ge) begin
               sq_v_in   = sq_v_ff - sq_try[63:0];
               sq_res_in = (sq_res_ff >> 1) + sq_bit_ff;
            end else begin
               sq_res_in = sq_res_ff >> 1;
            end
            sq_bit_in = sq_bit_ff >> 2;
            cnt_in    = cnt_ff + 5'd1;
            if (cnt_ff == 5'(SQRT_STEPS - 1)) begin
               state_in = ST_DIVX_INIT;
            end
         end
         ST_DIVX_INIT, ST_DIVY_INIT: begin
            rem_in   = {1'b0, div_mag[31:1]};
            sh_in    = {div_mag[0], {NORM_SHIFT{1'b0}}};
            cnt_in   = '0;
            state_in = (state_ff == ST_DIVX_INIT) ? ST_DIVX_RUN : ST_DIVY_RUN;
         end
         ST_DIVX_RUN, ST_DIVY_RUN: begin
            rem_in = div_ge ? 32'(div_t - {1'b0, sq_res_ff[31:0]}) : div_t[31:0];
            sh_in  = {sh_ff[DIV_STEPS-2:0], div_ge};
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'(DIV_STEPS - 1)) begin
               if (state_ff == ST_DIVX_RUN) begin
                  nx_in    = quot;
                  state_in = ST_DIVY_INIT;
               end else begin
                  ny_in    = quot;
                  state_in = ST_VA1;
               end
            end
         end
         ST_VA1: state_in = ST_VA2;
         ST_VA2: begin
            p1_in    = $signed(mul_q_ff[61:0]);
            state_in = ST_VB1;
         end
         ST_VB1: begin
            vna_in   = dot[62:NORM_SHIFT];
            state_in = ST_VB2;
         end
         ST_VB2: begin
            p1_in    = $signed(mul_q_ff[61:0]);
            state_in = ST_K;
         end
         ST_K: begin
            k_in     = 36'($signed(dot[62:NORM_SHIFT])) - 36'(vna_ff);
            state_in = ST_DDX;
         end
         ST_DDX: state_in = ST_DDY;
         ST_DDY: begin
            a_in.vx  = sat32(48'(a_ff.vx) + 48'(dd));
            b_in.vx  = sat32(48'(b_ff.vx) - 48'(dd));
            state_in = ST_UPDY;
         end
         ST_UPDY: begin
            a_in.vy  = sat32(48'(a_ff.vy) + 48'(dd));
            b_in.vy  = sat32(48'(b_ff.vy) - 48'(dd));
            state_in = ST_PB_WR;
         end
         ST_PB_WR: begin
            wr_en   = 1'b1;
            wr_addr = j_ff;
            wr_data = b_ff;
            if (j_ff == LAST) begin
               state_in = ST_PA_WR;
            end else begin
               j_in     = j_ff + BW'(1);
               state_in = ST_PB_RD;
            end
         end
         ST_PA_WR: begin
            wr_en = 1'b1;
            if (i_ff == LAST - BW'(1)) begin
               i_in     = '0;
               state_in = ST_EM_RD;
            end else begin
               i_in     = i_ff + BW'(1);
               state_in = ST_PA_RD;
            end
         end
         ST_EM_RD: state_in = ST_EM_OUT;
         ST_EM_OUT: begin
            rsp_valid_in = 1'b1;
            rsp_idx_in   = idx_w[3:0];
            rsp_ball_in  = rd_ball;
            rsp_last_in  = (i_ff == LAST);
            if (i_ff == LAST) begin
               state_in = ST_IDLE;
            end else begin
               i_in     = i_ff + BW'(1);
               state_in = ST_EM_RD;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         i_ff         <= '0;
         j_ff         <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         grav_ff      <= GRAVITY_RST;
         radius_ff    <= RADIUS_RST;
         xlo_ff       <= X_LOW_RST;
         xhi_ff       <= X_HIGH_RST;
         ylo_ff       <= Y_LOW_RST;
         yhi_ff       <= Y_HIGH_RST;
      end else begin
         state_ff     <= state_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         grav_ff      <= grav_in;
         radius_ff    <= radius_in;
         xlo_ff       <= xlo_in;
         xhi_ff       <= xhi_in;
         ylo_ff       <= ylo_in;
         yhi_ff       <= yhi_in;
      end
   end

   always_ff @(posedge clock) begin
      dt_ff       <= dt_in;
      gdt_ff      <= gdt_in;
      tr2_ff      <= tr2_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      dx_ff       <= dx_in;
      dy_ff       <= dy_in;
      sx_ff       <= sx_in;
      mul_q_ff    <= mul_q_in;
      sq_v_ff     <= sq_v_in;
      sq_res_ff   <= sq_res_in;
      sq_bit_ff   <= sq_bit_in;
      rem_ff      <= rem_in;
      sh_ff       <= sh_in;
      nx_ff       <= nx_in;
      ny_ff       <= ny_in;
      p1_ff       <= p1_in;
      vna_ff      <= vna_in;
      k_ff        <= k_in;
      rsp_last_ff <= rsp_last_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_ball_ff <= rsp_ball_in;
   end

   // ball memory, unwritten entries read as zero
   always_ff @(posedge clock) begin
      if (wr_en) begin
         ball_mem[wr_addr] <= wr_data;
      end
      mem_q_ff <= ball_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         vld_q_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         vld_q_ff <= valid_ff[rd_addr];
      end
   end

endmodule
`default_nettype wire

/* rtl/core/ebp_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ebp_checker
// Port-level checks of the elastic ball physics step, bound to the top level.
// ----------------------------------------------------------------------------
module ebp_checker #(
   parameter int BALL_COUNT = ebp_pkg::BALL_COUNT_DEF
) (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       start,
   input wire logic       busy,
   input wire logic       req_type,
   input wire logic       rsp_valid,
   input wire logic [3:0] rsp_out_index,
   input wire logic       rsp_last_ball
);
   import ebp_pkg::*;

   localparam logic [3:0] LAST_IDX = 4'(BALL_COUNT - 1);

   a_rsp_in_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result outside a step");

   a_rsp_spacing: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("results back to back");

   a_last_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_ball |-> rsp_out_index == LAST_IDX)
      else $error("last ball flag on wrong index");

   a_step_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_type == REQ_STEP |=> busy)
      else $error("step request not taken");

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_ball |=> !busy)
      else $error("busy after last result");

endmodule

bind elastic_ball_physics_step ebp_checker #(.BALL_COUNT(BALL_COUNT)) u_ebp_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .req_type      (req_type),
   .rsp_valid     (rsp_valid),
   .rsp_out_index (rsp_out_index),
   .rsp_last_ball (rsp_last_ball)
);
`default_nettype wire

/* verif/elastic_ball_physics_step_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elastic_ball_physics_step_test
// Self-checking bench for the ball physics step: loads balls, runs steps under
// several box, radius and gravity settings, and compares every emitted ball
// against an in-bench fixed-point predictor of the whole step.
// ----------------------------------------------------------------------------
module elastic_ball_physics_step_test;
   import ebp_pkg::*;

   localparam int  NBALL      = BALL_COUNT_DEF;
   localparam int  LIMIT      = 3000000;
   localparam real HALF_CYCLE = 6.0;

   typedef struct {
      logic [3:0]  index;
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] vx;
      logic [31:0] vy;
      logic        last;
   } ball_result_type;

   typedef struct {
      logic        kind;
      logic [3:0]  index;
      int          x;
      int          y;
      int          vx;
      int          vy;
      logic [15:0] dt;
      bit          typed;
      int          ex;
      int          ey;
      int          evx;
      int          evy;
   } request_row_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   logic              req_type = REQ_LOAD;
   logic [3:0]        req_ball_index = '0;
   logic signed [31:0] req_load_x = '0;
   logic signed [31:0] req_load_y = '0;
   logic signed [31:0] req_load_vx = '0;
   logic signed [31:0] req_load_vy = '0;
   logic [15:0]       req_time_delta = '0;
   logic              rsp_valid;
   logic [3:0]        rsp_out_index;
   logic signed [31:0] rsp_out_x;
   logic signed [31:0] rsp_out_y;
   logic signed [31:0] rsp_out_vx;
   logic signed [31:0] rsp_out_vy;
   logic              rsp_last_ball;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [CSR_IW-1:0] csr_index = CSR_GRAVITY;
   logic [CSR_DW-1:0] csr_data = '0;

   // predictor state
   int     gravity_q;
   longint radius_q;
   longint x_low_q, x_high_q, y_low_q, y_high_q;
   int     pos_x_q[NBALL];
   int     pos_y_q[NBALL];
   int     vel_x_q[NBALL];
   int     vel_y_q[NBALL];

   ball_result_type balls_due[$];
   int     mismatch_count = 0;
   bit     failed = 1'b0;
   int     cycle_count = 0;
   bit     burst = 1'b0;

   elastic_ball_physics_step i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_type(req_type), .req_ball_index(req_ball_index),
      .req_load_x(req_load_x), .req_load_y(req_load_y),
      .req_load_vx(req_load_vx), .req_load_vy(req_load_vy),
      .req_time_delta(req_time_delta),
      .rsp_valid(rsp_valid), .rsp_out_index(rsp_out_index),
      .rsp_out_x(rsp_out_x), .rsp_out_y(rsp_out_y),
      .rsp_out_vx(rsp_out_vx), .rsp_out_vy(rsp_out_vy),
      .rsp_last_ball(rsp_last_ball),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always #(HALF_CYCLE) clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   function automatic int clip32(longint v);
      if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'h8000_0000;
      return int'(v);
   endfunction

   function automatic longint unsigned root64(longint unsigned v);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v = v - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   function automatic void bounce_axis(inout int p, inout int v, input longint lo,
                                       input longint hi);
      if (longint'(p) - radius_q < lo) begin
         p = clip32(lo + radius_q);
         v = clip32(-longint'(v));
      end
      if (longint'(p) + radius_q > hi) begin
         p = clip32(hi - radius_q);
         v = clip32(-longint'(v));
      end
   endfunction

   function automatic void exchange_pair(int a, int b);
      longint dx, dy, nx, ny, vna, vnb, k, ddx, ddy, len;
      longint unsigned mx, my, sx, sy, d2, twor;
      dx = longint'(pos_x_q[b]) - longint'(pos_x_q[a]);
      dy = longint'(pos_y_q[b]) - longint'(pos_y_q[a]);
      mx = (dx < 0) ? -dx : dx;
      my = (dy < 0) ? -dy : dy;
      sx = mx * mx;
      sy = my * my;
      d2 = sx + sy;
      twor = 2 * radius_q;
      if (d2 < sx) d2 = 64'hFFFF_FFFF_FFFF_FFFF;
      if (d2 == 0 || d2 >= twor * twor) return;
      len = longint'(root64(d2));
      nx = (dx * (64'sd1 << NORM_SHIFT)) / len;
      ny = (dy * (64'sd1 << NORM_SHIFT)) / len;
      vna = (longint'(vel_x_q[a]) * nx + longint'(vel_y_q[a]) * ny) >>> NORM_SHIFT;
      vnb = (longint'(vel_x_q[b]) * nx + longint'(vel_y_q[b]) * ny) >>> NORM_SHIFT;
      k = vnb - vna;
      ddx = (k * nx) >>> NORM_SHIFT;
      ddy = (k * ny) >>> NORM_SHIFT;
      vel_x_q[a] = clip32(longint'(vel_x_q[a]) + ddx);
      vel_y_q[a] = clip32(longint'(vel_y_q[a]) + ddy);
      vel_x_q[b] = clip32(longint'(vel_x_q[b]) - ddx);
      vel_y_q[b] = clip32(longint'(vel_y_q[b]) - ddy);
   endfunction

   function automatic void predict_step(logic [15:0] dt);
      longint d;
      ball_result_type r;
      d = longint'(dt);
      for (int i = 0; i < NBALL; i++) begin
         vel_y_q[i] = clip32(longint'(vel_y_q[i]) + ((longint'(gravity_q) * d) >>> 16));
         pos_x_q[i] = clip32(longint'(pos_x_q[i]) + ((longint'(vel_x_q[i]) * d) >>> 16));
         pos_y_q[i] = clip32(longint'(pos_y_q[i]) + ((longint'(vel_y_q[i]) * d) >>> 16));
      end
      for (int i = 0; i < NBALL; i++) begin
         bounce_axis(pos_x_q[i], vel_x_q[i], x_low_q, x_high_q);
         bounce_axis(pos_y_q[i], vel_y_q[i], y_low_q, y_high_q);
      end
      for (int i = 0; i < NBALL - 1; i++)
         for (int j = i + 1; j < NBALL; j++)
            exchange_pair(i, j);
      for (int i = 0; i < NBALL; i++) begin
         r.index = i[3:0];
         r.x = pos_x_q[i];
         r.y = pos_y_q[i];
         r.vx = vel_x_q[i];
         r.vy = vel_y_q[i];
         r.last = (i == NBALL - 1);
         balls_due.push_back(r);
      end
   endfunction

   // result checker
   always @(posedge clock) begin
      ball_result_type e;
      if (!reset && rsp_valid) begin
         if (balls_due.size() == 0) begin
            failed = 1'b1;
            if (mismatch_count < 10)
               $display("unexpected result for ball %0d", rsp_out_index);
            mismatch_count++;
         end else begin
            e = balls_due.pop_front();
            if (e.index !== rsp_out_index || e.x !== rsp_out_x || e.y !== rsp_out_y ||
                e.vx !== rsp_out_vx || e.vy !== rsp_out_vy ||
                e.last !== rsp_last_ball) begin
               failed = 1'b1;
               if (mismatch_count < 10)
                  $display("mismatch ball %0d: exp x=%h y=%h vx=%h vy=%h last=%b, got %0d x=%h y=%h vx=%h vy=%h last=%b",
                           e.index, e.x, e.y, e.vx, e.vy, e.last, rsp_out_index,
                           rsp_out_x, rsp_out_y, rsp_out_vx, rsp_out_vy, rsp_last_ball);
               mismatch_count++;
            end
         end
      end
   end

   task automatic send_request(request_row_type row);
      int gap;
      ball_result_type r;
      gap = burst ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_type <= row.kind;
      req_ball_index <= row.index;
      req_load_x <= row.x;
      req_load_y <= row.y;
      req_load_vx <= row.vx;
      req_load_vy <= row.vy;
      req_time_delta <= row.dt;
      do @(posedge clock); while (busy);
      if (row.kind == REQ_LOAD) begin
         pos_x_q[row.index] = row.x;
         pos_y_q[row.index] = row.y;
         vel_x_q[row.index] = row.vx;
         vel_y_q[row.index] = row.vy;
      end else if (row.typed) begin
         predict_step(row.dt);
         repeat (NBALL) void'(balls_due.pop_back());
         for (int i = 0; i < NBALL; i++) begin
            r.index = i[3:0];
            r.x = row.ex;
            r.y = row.ey;
            r.vx = row.evx;
            r.vy = row.evy;
            r.last = (i == NBALL - 1);
            balls_due.push_back(r);
         end
      end else begin
         predict_step(row.dt);
      end
   endtask

   task automatic write_csr(logic [CSR_IW-1:0] idx, logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_GRAVITY: gravity_q = value;
         CSR_RADIUS:  radius_q = longint'(value[30:0]);
         CSR_X_LOW:   x_low_q = longint'(signed'(value));
         CSR_X_HIGH:  x_high_q = longint'(signed'(value));
         CSR_Y_LOW:   y_low_q = longint'(signed'(value));
         CSR_Y_HIGH:  y_high_q = longint'(signed'(value));
         default: ;
      endcase
   endtask

   task automatic settle;
      start <= 1'b0;
      while (balls_due.size() != 0 || busy) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   function automatic request_row_type load_row(logic [3:0] idx, int x, int y, int vx,
                                                int vy);
      request_row_type row;
      row = '{kind: REQ_LOAD, index: idx, x: x, y: y, vx: vx, vy: vy, dt: 16'd0,
              typed: 1'b0, ex: 0, ey: 0, evx: 0, evy: 0};
      return row;
   endfunction

   function automatic request_row_type step_row(logic [15:0] dt);
      request_row_type row;
      row = load_row(4'd0, 0, 0, 0, 0);
      row.kind = REQ_STEP;
      row.dt = dt;
      return row;
   endfunction

   function automatic request_row_type random_row();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 2)
         return step_row((pick == 0) ? 16'($urandom_range(0, 65535))
                                     : 16'($urandom_range(0, 4096)));
      if (pick < 8)
         return load_row(4'($urandom_range(0, 15)),
                         int'($urandom_range(0, 393216)) - 196608,
                         int'($urandom_range(0, 393216)) - 196608,
                         int'($urandom_range(0, 262144)) - 131072,
                         int'($urandom_range(0, 262144)) - 131072);
      return load_row(4'($urandom_range(0, 15)), $urandom, $urandom, $urandom, $urandom);
   endfunction

   initial begin
      request_row_type stim_table[$];
      request_row_type row;
      int cfg_table[4][6];

      gravity_q = GRAVITY_RST;
      radius_q = longint'(RADIUS_RST);
      x_low_q = X_LOW_RST;
      x_high_q = X_HIGH_RST;
      y_low_q = Y_LOW_RST;
      y_high_q = Y_HIGH_RST;
      for (int i = 0; i < NBALL; i++) begin
         pos_x_q[i] = 0;
         pos_y_q[i] = 0;
         vel_x_q[i] = 0;
         vel_y_q[i] = 0;
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part under reset settings
      row = step_row(16'd0);
      row.typed = 1'b1;
      stim_table.push_back(row);
      stim_table.push_back(load_row(4'd0, 32'h8000_0000, 32'h7FFF_FFFF,
                                    32'h7FFF_FFFF, 32'h8000_0000));
      stim_table.push_back(load_row(4'd15, 32'h7FFF_FFFF, 32'h8000_0000,
                                    32'h8000_0000, 32'h7FFF_FFFF));
      stim_table.push_back(step_row(16'hFFFF));
      stim_table.push_back(load_row(4'd1, 0, 0, 65536, 0));
      stim_table.push_back(load_row(4'd2, 32768, 0, -65536, 0));
      stim_table.push_back(load_row(4'd3, 200000, 100000, 5000, -7000));
      stim_table.push_back(load_row(4'd4, 200000, 100000, -3000, 9000));
      stim_table.push_back(load_row(4'd5, 20000, 20000, 0, 131072));
      stim_table.push_back(step_row(16'd1000));
      stim_table.push_back(step_row(16'd0));
      stim_table.push_back(load_row(4'd6, 655360, -655360, 32'h7FFF_0000, 12345));
      stim_table.push_back(step_row(16'hFFFF));
      stim_table.push_back(step_row(16'h5555));
      stim_table.push_back(step_row(16'hAAAA));
      foreach (stim_table[n]) send_request(stim_table[n]);
      settle();

      cfg_table[0] = '{int'($urandom_range(0, 1310720)) - 655360,
                       int'($urandom_range(16384, 98304)),
                       -int'($urandom_range(3, 10)) * 65536, int'($urandom_range(3, 10)) * 65536,
                       -int'($urandom_range(3, 10)) * 65536, int'($urandom_range(3, 10)) * 65536};
      cfg_table[1] = '{32'h7FFF_FFFF, 0, 32'h8000_0000, 32'h7FFF_FFFF,
                       32'h8000_0000, 32'h7FFF_FFFF};
      // box smaller than a ball, inverted on x
      cfg_table[2] = '{32'h8000_0000, 32'hFFFF_FFFF, 65536, -65536, 0, 0};
      cfg_table[3] = '{$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};

      for (int p = 0; p < 4; p++) begin
         for (int r = 0; r < 6; r++) write_csr(r[CSR_IW-1:0], cfg_table[p][r]);
         csr_valid <= 1'b0;
         for (int n = 0; n < 25; n++) begin
            if (n % 8 == 0) burst = ($urandom_range(0, 2) == 0);
            row = random_row();
            send_request(row);
         end
         if (p != 3) send_request(step_row(16'($urandom_range(0, 65535))));
         settle();
      end

      start <= 1'b0;
      while (balls_due.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (!failed && balls_due.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

/* filelist.f */
rtl/core/ebp_pkg.sv
rtl/core/elastic_ball_physics_step.sv
rtl/core/ebp_checker.sv
verif/elastic_ball_physics_step_test.sv
